### rtl/core/text_console_glyph_renderer_defines.svh
// Assertion macros shared by the checker.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TCGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

  localparam int unsigned PIX_W    = 24;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned FROW_W   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INK_COLOR    = 3'd0,
    REG_GLYPH_WIDTH  = 3'd1,
    REG_GLYPH_HEIGHT = 3'd2,
    REG_TEXT_COLUMNS = 3'd3,
    REG_TEXT_LINES   = 3'd4,
    REG_LINE_PITCH   = 3'd5,
    REG_WRAP_ENABLE  = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [23:0] INK_COLOR_RST    = 24'hFFFFFF;
  localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd6;
  localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd11;
  localparam logic [9:0]  TEXT_COLUMNS_RST = 10'd80;
  localparam logic [9:0]  TEXT_LINES_RST   = 10'd25;
  localparam logic [11:0] LINE_PITCH_RST   = 12'd1024;

endpackage

`default_nettype wire

### rtl/core/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake            Payload
// in       in_valid / in_ready  mode, char_code, font_row, font_bits
// out      out_valid/out_ready  clear_screen, pixel_index, row_pixels, paint_color, last
// cfg      cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// Font loads, newlines and dropped characters complete in S_IDLE, which stays ready.
// A drawn character passes through two multiply stages for the cell address
// (S_MUL1, S_MUL2), S_CLEAR at cursor 0,0 for the clear transaction, and S_ROWS for
// the effective glyph height rows, one font store read per cycle while out is not stalled.
// rst clears cursor, registers and handshake state; the font store is not cleared.
// A stall on out holds the row pointer and re-reads the same store entry.

module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int unsigned MAX_GLYPH_ROWS = 32,
  parameter int unsigned CHAR_COUNT     = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input transactions
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [CODE_W-1:0]     char_code,
  input  wire logic [FROW_W-1:0]     font_row,
  input  wire logic [ROW_W-1:0]      font_bits,
  // result transactions
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       clear_screen,
  output logic [PIX_W-1:0]           pixel_index,
  output logic [ROW_W-1:0]           row_pixels,
  output logic [COLOR_W-1:0]         paint_color,
  output logic                       last,
  // configuration writes
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DEPTH   = CHAR_COUNT * MAX_GLYPH_ROWS;
  localparam int unsigned AW      = $clog2(DEPTH);
  // Rows a glyph can actually use
  localparam int unsigned ROW_CAP = (MAX_GLYPH_ROWS < 32) ? MAX_GLYPH_ROWS : 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_CLEAR,
    S_ROWS
  } state_t;

  state_t state;

  // Configuration registers
  logic [23:0] ink_color;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [9:0]  text_columns;
  logic [9:0]  text_lines;
  logic [11:0] line_pitch;
  logic        wrap_enable;

  // Cursor
  logic [9:0] cursor_column;
  logic [9:0] cursor_line;

  // Per-character working registers
  logic [CODE_W-1:0] code_r;
  logic              char_ok;
  logic              need_clear;
  logic [15:0]       line_rows;   // cursor_line * glyph height
  logic [14:0]       col_pix;     // cursor_column * glyph width
  logic [AW-1:0]     char_base;
  logic [PIX_W-1:0]  pix;
  logic [4:0]        row_cnt;
  logic [AW-1:0]     mem_addr;

  // Font store
  logic [ROW_W-1:0] font_mem [DEPTH];
  logic [ROW_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  // Effective register values (zero and oversize clamped)
  logic [4:0]  gw_eff;
  logic [5:0]  gh_eff;
  logic [9:0]  cols_eff;
  logic [9:0]  lines_m1;
  logic [15:0] wmask;

  logic        in_take;
  logic        emit;
  logic        fire;
  logic        row_last;
  logic        put_drop;
  logic [9:0]  col_inc;
  logic [9:0]  line_inc;
  logic [9:0]  line_adv;
  logic [27:0] base_prod;

  always_comb begin
    if (glyph_width == 5'd0) begin
      gw_eff = 5'd1;
    end else if (glyph_width > 5'd16) begin
      gw_eff = 5'd16;
    end else begin
      gw_eff = glyph_width;
    end
    if (glyph_height == 6'd0) begin
      gh_eff = 6'd1;
    end else if (glyph_height > 6'(ROW_CAP)) begin
      gh_eff = 6'(ROW_CAP);
    end else begin
      gh_eff = glyph_height;
    end
    cols_eff = (text_columns == 10'd0) ? 10'd1 : text_columns;
    lines_m1 = (text_lines == 10'd0) ? 10'd0 : text_lines - 10'd1;
  end

  // Top gw_eff bits kept
  assign wmask = ~(16'hFFFF >> gw_eff);

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign emit     = !out_valid || out_ready;
  // a result transaction is loaded this cycle
  assign fire     = emit && ((state == S_CLEAR) || (state == S_ROWS));
  assign row_last = ({1'b0, row_cnt} + 6'd1) == gh_eff;
  assign put_drop = (cursor_column >= cols_eff) || (cursor_line >= lines_m1);

  assign col_inc  = cursor_column + 10'd1;
  assign line_inc = cursor_line + 10'd1;
  assign line_adv = (line_inc >= lines_m1) ? 10'd0 : line_inc;

  assign base_prod = {12'd0, line_rows} * {16'd0, line_pitch};

  // Font load address; out-of-range loads are ignored
  assign wr_addr = AW'(char_code) * AW'(MAX_GLYPH_ROWS) + AW'(font_row);
  assign wr_en   = in_take && !mode
                   && ({1'b0, char_code} < 9'(CHAR_COUNT))
                   && ({2'b0, font_row} < 7'(MAX_GLYPH_ROWS));

  // mem_addr registers the read address, so rd_data always tracks mem_addr
  always_comb begin
    unique case (state)
      S_MUL2:  rd_addr = char_base;
      S_ROWS:  rd_addr = (emit && !row_last) ? mem_addr + AW'(1) : mem_addr;
      default: rd_addr = mem_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_addr] <= font_bits;
    end
    rd_data <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      cursor_column <= 10'd0;
      cursor_line   <= 10'd0;
      ink_color     <= INK_COLOR_RST;
      glyph_width   <= GLYPH_WIDTH_RST;
      glyph_height  <= GLYPH_HEIGHT_RST;
      text_columns  <= TEXT_COLUMNS_RST;
      text_lines    <= TEXT_LINES_RST;
      line_pitch    <= LINE_PITCH_RST;
      wrap_enable   <= 1'b0;
    end else begin
      mem_addr <= rd_addr;
      if (out_ready && !fire) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_INK_COLOR:    ink_color    <= cfg_data[23:0];
          REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[4:0];
          REG_GLYPH_HEIGHT: glyph_height <= cfg_data[5:0];
          REG_TEXT_COLUMNS: text_columns <= cfg_data[9:0];
          REG_TEXT_LINES:   text_lines   <= cfg_data[9:0];
          REG_LINE_PITCH:   line_pitch   <= cfg_data[11:0];
          REG_WRAP_ENABLE:  wrap_enable  <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_take && mode) begin
            if (char_code == NEWLINE_CODE) begin
              cursor_column <= 10'd0;
              cursor_line   <= line_adv;
            end else if (!put_drop) begin
              code_r     <= char_code;
              char_ok    <= {1'b0, char_code} < 9'(CHAR_COUNT);
              need_clear <= (cursor_column == 10'd0) && (cursor_line == 10'd0);
              state      <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          line_rows <= {6'd0, cursor_line} * {10'd0, gh_eff};
          col_pix   <= {5'd0, cursor_column} * {10'd0, gw_eff};
          char_base <= char_ok ? AW'(code_r) * AW'(MAX_GLYPH_ROWS) : '0;
          state     <= S_MUL2;
        end
        S_MUL2: begin
          pix     <= base_prod[PIX_W-1:0] + {9'd0, col_pix};
          row_cnt <= 5'd0;
          state   <= need_clear ? S_CLEAR : S_ROWS;
        end
        S_CLEAR: begin
          if (emit) begin
            out_valid    <= 1'b1;
            clear_screen <= 1'b1;
            pixel_index  <= '0;
            row_pixels   <= '0;
            paint_color  <= '0;
            last         <= 1'b0;
            state        <= S_ROWS;
          end
        end
        S_ROWS: begin
          if (emit) begin
            out_valid    <= 1'b1;
            clear_screen <= 1'b0;
            pixel_index  <= pix;
            row_pixels   <= char_ok ? (rd_data & wmask) : '0;
            paint_color  <= ink_color;
            last         <= row_last;
            pix          <= pix + {12'd0, line_pitch};
            row_cnt      <= row_cnt + 5'd1;
            if (row_last) begin
              state <= S_IDLE;
              // advance cursor, wrapping to a new line if enabled
              if ((col_inc >= cols_eff) && wrap_enable) begin
                cursor_column <= 10'd0;
                cursor_line   <= line_adv;
              end else begin
                cursor_column <= col_inc;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcgr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_glyph_renderer_defines.svh"

module tcgr_checker
  import tcgr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               clear_screen,
  input wire logic [PIX_W-1:0]   pixel_index,
  input wire logic [ROW_W-1:0]   row_pixels,
  input wire logic [COLOR_W-1:0] paint_color,
  input wire logic               last
);

  // stalled result holds
  `TCGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_index) && $stable(row_pixels) && $stable(last), "result changed while stalled")

  // clear transaction carries nothing else
  `TCGR_ASSERT_NOW(a_clear_empty, out_valid && clear_screen, pixel_index == '0 && row_pixels == '0 && paint_color == '0 && !last, "clear result with payload")

  // no new input while a character is still being drawn
  `TCGR_ASSERT_NOW(a_busy_mid_char, out_valid && !last, !in_ready, "input taken mid-character")

  // a clear result is never directly followed by another clear
  `TCGR_ASSERT_NEXT(a_clear_once, out_valid && out_ready && clear_screen, !(out_valid && clear_screen), "back-to-back clear results")

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcgr_pkg::*;

  // Rows per character in the font store; the store holds 256 characters.
  localparam int unsigned FONT_ROWS     = 32;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  // Loads, newlines and dropped characters finish at the edge that accepts them.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PUT  = 1'b1;

  // Characters whose 32 rows are all loaded early on, so they can always be drawn.
  localparam logic [CODE_W-1:0] CODE_LOW  = 8'h00;
  localparam logic [CODE_W-1:0] CODE_MID  = 8'h41;
  localparam logic [CODE_W-1:0] CODE_HIGH = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode = MODE_LOAD;
  logic [CODE_W-1:0]     char_code = '0;
  logic [FROW_W-1:0]     font_row = '0;
  logic [ROW_W-1:0]      font_bits = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  clear_screen;
  logic [PIX_W-1:0]      pixel_index;
  logic [ROW_W-1:0]      row_pixels;
  logic [COLOR_W-1:0]    paint_color;
  logic                  last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  text_console_glyph_renderer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .char_code    (char_code),
    .font_row     (font_row),
    .font_bits    (font_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clear_screen (clear_screen),
    .pixel_index  (pixel_index),
    .row_pixels   (row_pixels),
    .paint_color  (paint_color),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // One result transaction as the block should emit it.
  typedef struct packed {
    logic               clear;
    logic [PIX_W-1:0]   pixel;
    logic [ROW_W-1:0]   bits;
    logic [COLOR_W-1:0] color;
    logic               last;
  } glyph_row_t;

  glyph_row_t expected_rows[$];

  // Shadow copies of the registers, as raw written values.
  logic [23:0] ink_color_q    = INK_COLOR_RST;
  logic [4:0]  glyph_width_q  = GLYPH_WIDTH_RST;
  logic [5:0]  glyph_height_q = GLYPH_HEIGHT_RST;
  logic [9:0]  text_columns_q = TEXT_COLUMNS_RST;
  logic [9:0]  text_lines_q   = TEXT_LINES_RST;
  logic [11:0] line_pitch_q   = LINE_PITCH_RST;
  logic        wrap_q         = 1'b0;

  int unsigned cursor_col  = 0;
  int unsigned cursor_line = 0;

  // Font mirror plus a per-character mask of rows written so far; drawing is
  // only ever asked for characters whose visible rows are all loaded.
  logic [ROW_W-1:0]     font_copy [0:256*FONT_ROWS-1];
  logic [FONT_ROWS-1:0] rows_loaded [0:255];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int fail_count     = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: well above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int unsigned eff_width();
    if (glyph_width_q == 0) return 1;
    return (glyph_width_q > 16) ? 16 : glyph_width_q;
  endfunction

  function automatic int unsigned eff_height();
    if (glyph_height_q == 0) return 1;
    return (glyph_height_q > FONT_ROWS) ? FONT_ROWS : glyph_height_q;
  endfunction

  // Newline: column 0 of the next line; the last line is never drawn, so
  // reaching it wraps back to the top.
  function automatic void next_text_line(int unsigned lines);
    cursor_line = (cursor_line + 1) & 10'h3FF;
    cursor_col  = 0;
    if (cursor_line >= lines - 1) cursor_line = 0;
  endfunction

  // Works out what one accepted input transaction does to the console and
  // queues the rows it should produce.
  function automatic void predict_glyph_rows(logic m, logic [CODE_W-1:0] code,
                                             logic [FROW_W-1:0] frow,
                                             logic [ROW_W-1:0] bits);
    int unsigned gw;
    int unsigned gh;
    int unsigned cols;
    int unsigned lines;
    int unsigned r;
    logic [ROW_W-1:0] wmask;
    logic [63:0] base;
    glyph_row_t row;
    gw    = eff_width();
    gh    = eff_height();
    cols  = (text_columns_q == 0) ? 1 : text_columns_q;
    lines = (text_lines_q == 0) ? 1 : text_lines_q;
    wmask = 16'(32'hFFFF << (16 - gw));
    if (m == MODE_LOAD) begin
      font_copy[code*FONT_ROWS + frow] = bits;
      rows_loaded[code][frow] = 1'b1;
      return;
    end
    if (code == NEWLINE_CODE) begin
      next_text_line(lines);
      return;
    end
    // off the right edge or on the unusable bottom line: dropped silently
    if (cursor_col >= cols || cursor_line >= lines - 1) return;
    if (cursor_col == 0 && cursor_line == 0) begin
      row = '0;
      row.clear = 1'b1;
      expected_rows.push_back(row);
    end
    base = 64'(cursor_line) * gh * line_pitch_q + 64'(cursor_col) * gw;
    for (r = 0; r < gh; r++) begin
      row.clear = 1'b0;
      row.pixel = PIX_W'(base + 64'(r) * line_pitch_q);
      row.bits  = font_copy[code*FONT_ROWS + r] & wmask;
      row.color = ink_color_q;
      row.last  = (r + 1 == gh);
      expected_rows.push_back(row);
    end
    cursor_col = (cursor_col + 1) & 10'h3FF;
    if (cursor_col >= cols && wrap_q) next_text_line(lines);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: every result transaction against the oldest expectation.
  always @(posedge clk) begin
    glyph_row_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result: clear_screen %0b pixel_index %0h",
               clear_screen, pixel_index);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        check_field("clear_screen", 32'(want.clear), 32'(clear_screen));
        check_field("pixel_index",  32'(want.pixel), 32'(pixel_index));
        check_field("row_pixels",   32'(want.bits),  32'(row_pixels));
        check_field("paint_color",  32'(want.color), 32'(paint_color));
        check_field("last",         32'(want.last),  32'(last));
      end
    end
  end

  // Offers one input transaction after a random gap and returns at the edge
  // where it is taken. Valid stays high into the next call if there is no gap.
  task automatic send_item(logic m, logic [CODE_W-1:0] code, logic [FROW_W-1:0] frow,
                           logic [ROW_W-1:0] bits);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    char_code <= code;
    font_row  <= frow;
    font_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_glyph_rows(m, code, frow, bits);
  endtask

  // Sender pauses until every expected row has come out, then lets the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_INK_COLOR:    ink_color_q    = value[23:0];
      REG_GLYPH_WIDTH:  glyph_width_q  = value[4:0];
      REG_GLYPH_HEIGHT: glyph_height_q = value[5:0];
      REG_TEXT_COLUMNS: text_columns_q = value[9:0];
      REG_TEXT_LINES:   text_lines_q   = value[9:0];
      REG_LINE_PITCH:   line_pitch_q   = value[11:0];
      REG_WRAP_ENABLE:  wrap_q         = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // A printable character whose visible rows are all loaded.
  function automatic logic [CODE_W-1:0] pick_glyph();
    logic [CODE_W-1:0] code;
    logic [31:0] need;
    int unsigned gh;
    int i;
    gh   = eff_height();
    need = (gh >= 32) ? 32'hFFFF_FFFF : (32'd1 << gh) - 1;
    for (i = 0; i < 6; i++) begin
      code = $urandom_range(255);
      if (code != NEWLINE_CODE && (rows_loaded[code] & need) == need) return code;
    end
    case ($urandom_range(2))
      0:       return CODE_LOW;
      1:       return CODE_MID;
      default: return CODE_HIGH;
    endcase
  endfunction

  task automatic put_char(logic [CODE_W-1:0] code);
    send_item(MODE_PUT, code, $urandom_range(31), $urandom_range(16'hFFFF));
  endtask

  // Full fonts for three characters, with all-zero and all-one rows and both
  // ends of the row index.
  task automatic test_font_setup();
    int r;
    for (r = 0; r < FONT_ROWS; r++) begin
      send_item(MODE_LOAD, CODE_LOW, r, (r % 2 == 1) ? 16'hFFFF : 16'h0000);
      send_item(MODE_LOAD, CODE_MID, r, $urandom_range(16'hFFFF));
      send_item(MODE_LOAD, CODE_HIGH, r, (r == 0) ? 16'hFFFF : $urandom_range(16'hFFFF));
    end
  endtask

  // Reset register values: clear at the origin, a few cells, a newline.
  task automatic test_reset_defaults();
    put_char(CODE_MID);
    put_char(CODE_HIGH);
    put_char(CODE_LOW);
    put_char(NEWLINE_CODE);
    put_char(CODE_MID);
    wait_drained();
  endtask

  // Small screen: dropped characters past the right edge, newline wrap at the
  // bottom, then column overflow with wrapping on.
  task automatic test_cursor_edges();
    write_reg(REG_TEXT_COLUMNS, 2);
    write_reg(REG_TEXT_LINES, 3);
    write_reg(REG_GLYPH_HEIGHT, 3);
    write_reg(REG_GLYPH_WIDTH, 5);
    write_reg(REG_LINE_PITCH, 40);
    write_reg(REG_WRAP_ENABLE, 0);
    put_char(NEWLINE_CODE);
    put_char(NEWLINE_CODE);
    put_char(CODE_MID);
    put_char(CODE_HIGH);
    put_char(CODE_LOW);      // column 2: dropped
    put_char(NEWLINE_CODE);
    put_char(CODE_MID);
    put_char(NEWLINE_CODE);  // bottom line reached: back to line 0
    put_char(CODE_HIGH);     // origin again, so a clear first
    wait_drained();
    write_reg(REG_WRAP_ENABLE, 1);
    repeat (5) put_char(CODE_LOW);
    wait_drained();
  endtask

  // Register values at and past their ends, and a write to an unused index.
  task automatic test_register_extremes();
    write_reg(REG_GLYPH_WIDTH, 0);
    write_reg(REG_GLYPH_HEIGHT, 0);
    write_reg(REG_TEXT_COLUMNS, 0);
    write_reg(REG_TEXT_LINES, 0);
    write_reg(REG_WRAP_ENABLE, 0);
    put_char(NEWLINE_CODE);
    put_char(CODE_MID);      // no usable line at all: dropped
    wait_drained();
    write_reg(REG_TEXT_LINES, 2);
    write_reg(REG_INK_COLOR, 0);
    put_char(CODE_HIGH);     // one row, one pixel wide
    put_char(CODE_LOW);      // column count acts as 1: dropped
    put_char(NEWLINE_CODE);
    wait_drained();
    write_reg(REG_GLYPH_WIDTH, 31);
    write_reg(REG_GLYPH_HEIGHT, 63);
    write_reg(REG_TEXT_COLUMNS, 1023);
    write_reg(REG_TEXT_LINES, 1023);
    write_reg(REG_LINE_PITCH, 4095);
    write_reg(REG_INK_COLOR, 24'hFFFFFF);
    write_reg(REG_WRAP_ENABLE, 1);
    put_char(CODE_HIGH);
    put_char(CODE_LOW);
    wait_drained();
    write_reg(REG_GLYPH_WIDTH, 1);
    write_reg(REG_GLYPH_HEIGHT, 1);
    write_reg(REG_LINE_PITCH, 0);
    write_reg(REG_INK_COLOR, 24'h5A5A5A);
    write_reg(REG_UNUSED, 24'hFFFFFF);  // must leave everything alone
    put_char(CODE_MID);
    wait_drained();
    write_reg(REG_GLYPH_WIDTH, 16);
    write_reg(REG_GLYPH_HEIGHT, 32);
    put_char(CODE_MID);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // tall glyphs, so the block backs up and stalls its input.
  task automatic test_receiver_hold();
    write_reg(REG_GLYPH_HEIGHT, 32);
    write_reg(REG_TEXT_COLUMNS, 1023);
    write_reg(REG_TEXT_LINES, 1023);
    put_char(NEWLINE_CODE);
    hold_request = 600;
    repeat (12) put_char(pick_glyph());
    wait_drained();
  endtask

  // Far down a tall screen the pixel index passes 2^24 and must wrap.
  task automatic test_far_cursor();
    write_reg(REG_GLYPH_WIDTH, 16);
    write_reg(REG_GLYPH_HEIGHT, 32);
    write_reg(REG_TEXT_COLUMNS, 1023);
    write_reg(REG_TEXT_LINES, 1023);
    write_reg(REG_LINE_PITCH, 4095);
    write_reg(REG_WRAP_ENABLE, 0);
    repeat (140) put_char(NEWLINE_CODE);
    put_char(CODE_MID);
    put_char(CODE_HIGH);
    wait_drained();
  endtask

  // Random traffic in short runs, each under a freshly drawn register set.
  // Mostly whole-glyph loads followed by draws, plus stray loads and newlines.
  task automatic test_random_traffic(int items, int send_pct, int recv_pct);
    int sent;
    int run;
    int pick;
    int r;
    int unsigned gh;
    logic [CODE_W-1:0] code;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      wait_drained();
      write_reg(REG_INK_COLOR, $urandom_range(24'hFFFFFF));
      write_reg(REG_GLYPH_WIDTH, $urandom_range(31));
      write_reg(REG_GLYPH_HEIGHT,
                ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(6));
      write_reg(REG_TEXT_COLUMNS,
                ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(5));
      write_reg(REG_TEXT_LINES,
                ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(5));
      write_reg(REG_LINE_PITCH, $urandom_range(4095));
      write_reg(REG_WRAP_ENABLE, $urandom_range(1));
      run = 0;
      while (run < 35 && sent < items) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          code = $urandom_range(255);
          gh   = eff_height();
          for (r = 0; r < gh; r++)
            send_item(MODE_LOAD, code, r, $urandom_range(16'hFFFF));
          put_char(code);
          run  += gh + 1;
          sent += gh + 1;
        end else begin
          if (pick < 30)
            send_item(MODE_LOAD, $urandom_range(255), $urandom_range(31),
                      $urandom_range(16'hFFFF));
          else if (pick < 42)
            put_char(NEWLINE_CODE);
          else
            put_char(pick_glyph());
          run++;
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int c = 0; c < 256; c++) rows_loaded[c] = '0;
    send_idle_pct  = 9;
    recv_stall_pct = 62;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_font_setup();
    test_reset_defaults();
    test_cursor_edges();
    test_register_extremes();
    test_random_traffic(80, 9, 62);
    test_random_traffic(80, 62, 9);
    test_random_traffic(70, 0, 0);
    test_receiver_hold();
    test_far_cursor();

    // anything still in flight has had time to show itself by now
    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tcgr_pkg.sv
rtl/core/text_console_glyph_renderer.sv
rtl/core/tcgr_checker.sv
test/testbench.sv
